// ----- hw/rtl/rgbrle_pkg.sv -----
// ============================================================================
// rgbrle_pkg
// Shared types and constants for the RGB565 run-length packet encoder.
// ============================================================================
package rgbrle_pkg;

  // Default limits. The command and beat formats are sized for the largest
  // allowed MAX_PACKET (128) and PIXELS_PER_BEAT (4).
  localparam int MAX_PACKET      = 128;
  localparam int PIXELS_PER_BEAT = 4;

  localparam int PIX_W      = 16;
  localparam int LANES      = 4;   // pixel fields in one output word
  localparam int CNT_W      = 8;   // packet length, 1..128
  localparam int ADDR_W     = 8;   // literal ring address, up to 256 entries
  localparam int PCNT_W     = 3;   // pix_count field
  localparam int HDR_W      = 8;
  localparam int CMD_DEPTH  = 4;   // power of two
  localparam int TDATA_W    = 80;

  localparam logic HDR_REPEAT  = 1'b1;
  localparam logic HDR_LITERAL = 1'b0;

  // Packet command handed from the front end to the back end.
  typedef struct packed {
    logic              rep;         // repeat packet, else literal packet
    logic [PIX_W-1:0]  pixel;       // repeated pixel
    logic [CNT_W-1:0]  count;       // packet length in pixels
    logic [ADDR_W-1:0] start;       // first literal in the ring
    logic              last;        // last packet caused by the input word
    logic              frame_done;  // last packet of the frame
  } cmd_t;

  // Literal ring write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } lit_wr_t;

  // One output word.
  typedef struct packed {
    logic                        has_header;
    logic [HDR_W-1:0]            header;
    logic [PCNT_W-1:0]           pix_count;
    logic [LANES-1:0][PIX_W-1:0] pixel;
    logic                        packet_end;
    logic                        frame_done;
    logic                        last;
  } beat_t;

  function automatic logic [HDR_W-1:0] make_header(input logic rep,
                                                   input logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] len_m1;
    len_m1 = count - 1'b1;
    return {rep, len_m1[HDR_W-2:0]};
  endfunction

endpackage

// ----- hw/rtl/rgbrle_fifo.sv -----
// ============================================================================
// rgbrle_fifo
// Short command queue between the classifier and the packet writer.
// ============================================================================
module rgbrle_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rgbrle_pkg::cmd_t  din,
  input  logic              pop,
  output rgbrle_pkg::cmd_t  dout,
  output logic              full,
  output logic              empty
);

  localparam int DEPTH = rgbrle_pkg::CMD_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  rgbrle_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  logic do_push;
  logic do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/rgbrle_front.sv -----
// ============================================================================
// rgbrle_front
// Run classifier: tracks the current run, stores literals into the ring and
// issues repeat and literal packet commands.
// ============================================================================
module rgbrle_front #(
  parameter int MAX_PACKET = rgbrle_pkg::MAX_PACKET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rgbrle_pkg::PIX_W-1:0] pixel,
  input  logic                         frame_end,
  input  logic                         cmd_full,
  input  logic                         rd_free,
  output logic                         cmd_push,
  output rgbrle_pkg::cmd_t             cmd,
  output rgbrle_pkg::lit_wr_t          lit_wr
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int AW = $clog2(MAX_PACKET) + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_PACKET);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  logic [rgbrle_pkg::PIX_W-1:0] held_pixel, held_pixel_next;
  logic                         held_valid, held_valid_next;
  logic [CW-1:0]                run_len, run_len_next;
  logic [CW-1:0]                lit_cnt, lit_cnt_next;
  logic [AW-1:0]                wp, wp_next;
  logic [AW-1:0]                lit_base, lit_base_next;
  logic [AW:0]                  used, used_next;
  logic                         tail_rep, tail_rep_next;
  logic                         tail_fe, tail_fe_next;

  logic tail_pend;
  logic room;
  logic acc;
  logic tail_go;

  assign tail_pend = tail_rep || tail_fe;
  assign room      = !used[AW];           // ring not full
  assign s_tready  = !tail_pend && !cmd_full && room;
  assign acc       = s_tvalid && s_tready;
  assign tail_go   = tail_pend && !cmd_full && room;

  always_comb begin
    logic [CW-1:0] run_inc;
    logic [CW-1:0] lit_inc;
    logic          lit_flush;

    run_inc   = run_len + ONE;
    lit_inc   = lit_cnt + ONE;
    lit_flush = 1'b0;

    held_pixel_next = held_pixel;
    held_valid_next = held_valid;
    run_len_next    = run_len;
    lit_cnt_next    = lit_cnt;
    wp_next         = wp;
    lit_base_next   = lit_base;
    tail_rep_next   = tail_rep;
    tail_fe_next    = tail_fe;
    cmd_push        = 1'b0;
    cmd             = '0;
    lit_wr          = '0;

    if (acc) begin
      if (!held_valid) begin
        held_pixel_next = pixel;
        held_valid_next = 1'b1;
        run_len_next    = ONE;
      end else if (pixel == held_pixel) begin
        // a repeat starts: pending literals go out first
        lit_flush = (run_len == ONE) && (lit_cnt != '0);
        if (lit_flush) begin
          cmd_push      = 1'b1;
          cmd.rep       = rgbrle_pkg::HDR_LITERAL;
          cmd.count     = rgbrle_pkg::CNT_W'(lit_cnt);
          cmd.start     = rgbrle_pkg::ADDR_W'(lit_base);
          lit_cnt_next  = '0;
          lit_base_next = wp;
        end
        if (run_inc == MAXC) begin
          if (lit_flush) begin
            // second packet of this word goes out in the tail pass that follows
            tail_rep_next = 1'b1;
            run_len_next  = run_inc;
          end else begin
            cmd_push        = 1'b1;
            cmd.rep         = rgbrle_pkg::HDR_REPEAT;
            cmd.pixel       = held_pixel;
            cmd.count       = rgbrle_pkg::CNT_W'(run_inc);
            held_valid_next = 1'b0;
            run_len_next    = '0;
          end
        end else begin
          run_len_next = run_inc;
        end
      end else begin
        if (run_len >= TWO) begin
          cmd_push  = 1'b1;
          cmd.rep   = rgbrle_pkg::HDR_REPEAT;
          cmd.pixel = held_pixel;
          cmd.count = rgbrle_pkg::CNT_W'(run_len);
        end else begin
          lit_wr.en   = 1'b1;
          lit_wr.addr = rgbrle_pkg::ADDR_W'(wp);
          lit_wr.data = held_pixel;
          wp_next     = wp + 1'b1;
          if (lit_inc == MAXC) begin
            cmd_push      = 1'b1;
            cmd.rep       = rgbrle_pkg::HDR_LITERAL;
            cmd.count     = rgbrle_pkg::CNT_W'(lit_inc);
            cmd.start     = rgbrle_pkg::ADDR_W'(lit_base);
            lit_cnt_next  = '0;
            lit_base_next = wp + 1'b1;
          end else begin
            lit_cnt_next = lit_inc;
          end
        end
        held_pixel_next = pixel;
        held_valid_next = 1'b1;
        run_len_next    = ONE;
      end
      tail_fe_next   = frame_end && held_valid_next;
      cmd.last       = !(tail_rep_next || tail_fe_next);
      cmd.frame_done = frame_end && cmd.last;
    end else if (tail_go) begin
      cmd_push        = 1'b1;
      cmd.last        = 1'b1;
      cmd.frame_done  = tail_fe;
      held_valid_next = 1'b0;
      run_len_next    = '0;
      tail_rep_next   = 1'b0;
      tail_fe_next    = 1'b0;
      if (tail_rep || run_len >= TWO) begin
        cmd.rep   = rgbrle_pkg::HDR_REPEAT;
        cmd.pixel = held_pixel;
        cmd.count = rgbrle_pkg::CNT_W'(run_len);
      end else begin
        // frame end on a single pixel: push it and flush all literals
        lit_wr.en     = 1'b1;
        lit_wr.addr   = rgbrle_pkg::ADDR_W'(wp);
        lit_wr.data   = held_pixel;
        wp_next       = wp + 1'b1;
        cmd.rep       = rgbrle_pkg::HDR_LITERAL;
        cmd.count     = rgbrle_pkg::CNT_W'(lit_inc);
        cmd.start     = rgbrle_pkg::ADDR_W'(lit_base);
        lit_cnt_next  = '0;
        lit_base_next = wp + 1'b1;
      end
    end

    used_next = used + (AW+1)'(lit_wr.en) - (AW+1)'(rd_free);
  end

  always_ff @(posedge clk) begin
    held_pixel <= held_pixel_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      run_len    <= '0;
      lit_cnt    <= '0;
      wp         <= '0;
      lit_base   <= '0;
      used       <= '0;
      tail_rep   <= 1'b0;
      tail_fe    <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
      run_len    <= run_len_next;
      lit_cnt    <= lit_cnt_next;
      wp         <= wp_next;
      lit_base   <= lit_base_next;
      used       <= used_next;
      tail_rep   <= tail_rep_next;
      tail_fe    <= tail_fe_next;
    end
  end

endmodule

// ----- hw/rtl/rgbrle_back.sv -----
// ============================================================================
// rgbrle_back
// Packet writer: owns the literal ring, turns commands into output words.
// ============================================================================
module rgbrle_back #(
  parameter int MAX_PACKET      = rgbrle_pkg::MAX_PACKET,
  parameter int PIXELS_PER_BEAT = rgbrle_pkg::PIXELS_PER_BEAT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  rgbrle_pkg::cmd_t    cmd,
  output logic                cmd_pop,
  input  rgbrle_pkg::lit_wr_t lit_wr,
  output logic                rd_free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output rgbrle_pkg::beat_t   beat
);

  localparam int CW   = $clog2(MAX_PACKET + 1);
  localparam int AW   = $clog2(MAX_PACKET) + 1;
  localparam int RING = 1 << AW;
  localparam int LW   = $clog2(rgbrle_pkg::LANES);
  localparam logic [rgbrle_pkg::PCNT_W-1:0] PPB = rgbrle_pkg::PCNT_W'(PIXELS_PER_BEAT);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [rgbrle_pkg::PIX_W-1:0] lit_mem [RING];
  logic [rgbrle_pkg::PIX_W-1:0] rdata;

  logic                         rd_valid, rd_valid_next;
  logic [AW-1:0]                rd_addr, rd_addr_next;
  logic [CW-1:0]                rd_left, rd_left_next;
  logic [CW-1:0]                pl_left, pl_left_next;
  logic                         busy, busy_next;
  logic [rgbrle_pkg::HDR_W-1:0] cur_hdr, cur_hdr_next;
  logic                         cur_last, cur_last_next;
  logic                         cur_frame, cur_frame_next;
  rgbrle_pkg::beat_t            asm_beat, asm_beat_next;
  logic                         asm_done, asm_done_next;
  logic                         asm_first, asm_first_next;
  rgbrle_pkg::beat_t            out_beat, out_beat_next;
  logic                         out_valid, out_valid_next;

  logic          out_load;
  logic          asm_free;
  logic          place;
  logic          rd_en;
  logic [AW-1:0] rd_sel;

  assign out_load = asm_done && (!out_valid || m_tready);
  assign asm_free = !asm_done || out_load;
  assign place    = busy && rd_valid && asm_free;
  assign cmd_pop  = !busy && !cmd_empty && asm_free;
  assign rd_en    = (busy && (rd_left != '0) && (!rd_valid || place))
                 || (cmd_pop && !cmd.rep);
  assign rd_sel   = cmd_pop ? AW'(cmd.start) : rd_addr;
  assign rd_free  = rd_en;
  assign m_tvalid = out_valid;
  assign beat     = out_beat;

  always_comb begin
    logic [rgbrle_pkg::PCNT_W-1:0] cnt0;
    logic [rgbrle_pkg::PCNT_W-1:0] cnt1;
    logic                          pend;

    cnt0 = asm_done ? '0 : asm_beat.pix_count;
    cnt1 = cnt0 + 1'b1;
    pend = (pl_left == ONE);

    rd_addr_next   = rd_addr;
    rd_left_next   = rd_left;
    pl_left_next   = pl_left;
    busy_next      = busy;
    cur_hdr_next   = cur_hdr;
    cur_last_next  = cur_last;
    cur_frame_next = cur_frame;
    asm_beat_next  = asm_beat;
    asm_done_next  = asm_done && !out_load;
    asm_first_next = asm_first;
    rd_valid_next  = rd_en || (rd_valid && !place);

    if (cmd_pop) begin
      if (cmd.rep) begin
        asm_beat_next             = '0;
        asm_beat_next.has_header  = 1'b1;
        asm_beat_next.header      = rgbrle_pkg::make_header(rgbrle_pkg::HDR_REPEAT,
                                                            cmd.count);
        asm_beat_next.pix_count   = rgbrle_pkg::PCNT_W'(1);
        asm_beat_next.pixel[0]    = cmd.pixel;
        asm_beat_next.packet_end  = 1'b1;
        asm_beat_next.last        = cmd.last;
        asm_beat_next.frame_done  = cmd.frame_done;
        asm_done_next             = 1'b1;
      end else begin
        // first ring read goes out in the same cycle; assembly starts empty
        asm_beat_next  = '0;
        busy_next      = 1'b1;
        rd_addr_next   = AW'(cmd.start) + 1'b1;
        rd_left_next   = CW'(cmd.count) - ONE;
        pl_left_next   = CW'(cmd.count);
        cur_hdr_next   = rgbrle_pkg::make_header(rgbrle_pkg::HDR_LITERAL, cmd.count);
        cur_last_next  = cmd.last;
        cur_frame_next = cmd.frame_done;
        asm_first_next = 1'b1;
      end
    end else if (busy && rd_en) begin
      rd_addr_next = rd_addr + 1'b1;
      rd_left_next = rd_left - ONE;
    end

    if (place) begin
      asm_beat_next.pixel[cnt0[LW-1:0]] = rdata;
      asm_beat_next.pix_count           = cnt1;
      pl_left_next                      = pl_left - ONE;
      if (cnt1 == PPB || pend) begin
        asm_done_next            = 1'b1;
        asm_beat_next.has_header = asm_first;
        asm_beat_next.header     = asm_first ? cur_hdr : '0;
        asm_beat_next.packet_end = pend;
        asm_beat_next.last       = pend && cur_last;
        asm_beat_next.frame_done = pend && cur_frame;
        asm_first_next           = 1'b0;
        if (pend) begin
          busy_next = 1'b0;
        end
      end
    end

    // unused lanes leave as zero
    out_beat_next = asm_beat;
    for (int i = 0; i < rgbrle_pkg::LANES; i++) begin
      if (rgbrle_pkg::PCNT_W'(i) >= asm_beat.pix_count) begin
        out_beat_next.pixel[i] = '0;
      end
    end
    out_valid_next = out_load || (out_valid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      lit_mem[AW'(lit_wr.addr)] <= lit_wr.data;
    end
    if (rd_en) begin
      rdata <= lit_mem[rd_sel];
    end
  end

  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    cur_hdr   <= cur_hdr_next;
    cur_last  <= cur_last_next;
    cur_frame <= cur_frame_next;
    asm_beat  <= asm_beat_next;
    if (out_load) begin
      out_beat <= out_beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_left   <= '0;
      pl_left   <= '0;
      busy      <= 1'b0;
      asm_done  <= 1'b0;
      asm_first <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid  <= rd_valid_next;
      rd_left   <= rd_left_next;
      pl_left   <= pl_left_next;
      busy      <= busy_next;
      asm_done  <= asm_done_next;
      asm_first <= asm_first_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- hw/rtl/rgb565_run_length_encoder.sv -----
// ============================================================================
// rgb565_run_length_encoder
// Run-length packet encoder for 16-bit RGB565 pixel streams.
// ============================================================================
// One pixel comes in per input word, s_tlast marking the last pixel of a
// frame. Runs of 2..MAX_PACKET equal pixels become a repeat packet (header
// 0x80 | (length-1), one pixel); other pixels collect into literal packets
// (header length-1, 1..MAX_PACKET pixels), flushed when a repeat starts,
// when MAX_PACKET are held or at frame end. Each output word carries an
// optional header and up to PIXELS_PER_BEAT pixels; unused pixel fields are
// zero, and the header field is zero on words without a header.
// A word with s_tlast needs a second classifier pass when a pixel is still
// held after it (the frame-end flush), as does a literal flush followed by
// a full-length repeat in the same word. No input word is taken meanwhile.
// The classifier stalls when the four-entry command queue or the literal
// ring (2^(clog2(MAX_PACKET)+1) pixels) is full. The packet writer reads
// the ring one pixel per cycle while its output is not stalled; a repeat
// packet is built from its command alone, with no ring read. Each packet
// command passes through the command queue; the writer then fills the
// assembly register (for literals from registered ring reads) and hands
// each word to the output register. No clearing pass after reset.
// ============================================================================
module rgb565_run_length_encoder #(
  parameter int MAX_PACKET      = rgbrle_pkg::MAX_PACKET,      // 2..128
  parameter int PIXELS_PER_BEAT = rgbrle_pkg::PIXELS_PER_BEAT  // 1..4
) (
  input  logic                              clk,
  input  logic                              rst,
  // input pixels
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rgbrle_pkg::PIX_W-1:0]      s_tdata,   // [15:0] pixel
  input  logic                              s_tlast,   // frame_end
  // output words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] header, [10:8] pix_count, [26:11] pixel_0, [42:27] pixel_1,
  // [58:43] pixel_2, [74:59] pixel_3, [75] packet_end, [76] last,
  // [79:77] zero
  output logic [rgbrle_pkg::TDATA_W-1:0]    m_tdata,
  output logic [0:0]                        m_tuser,   // [0] has_header
  output logic                              m_tlast    // frame_done
);

  localparam logic [rgbrle_pkg::PCNT_W-1:0] PPB = rgbrle_pkg::PCNT_W'(PIXELS_PER_BEAT);

  // front -> queue
  logic                cmd_push;
  rgbrle_pkg::cmd_t    cmd_in;
  logic                cmd_full;
  // queue -> back
  logic                cmd_pop;
  rgbrle_pkg::cmd_t    cmd_out;
  logic                cmd_empty;
  // literal ring traffic
  rgbrle_pkg::lit_wr_t lit_wr;
  logic                rd_free;
  // output word
  rgbrle_pkg::beat_t   beat;

  // Classifier: run tracking, literal writes, packet commands.
  rgbrle_front #(
    .MAX_PACKET (MAX_PACKET)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .pixel     (s_tdata),
    .frame_end (s_tlast),
    .cmd_full  (cmd_full),
    .rd_free   (rd_free),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .lit_wr    (lit_wr)
  );

  // Decouples the classifier from output backpressure.
  rgbrle_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  // Packet writer with the literal ring and the output register.
  rgbrle_back #(
    .MAX_PACKET      (MAX_PACKET),
    .PIXELS_PER_BEAT (PIXELS_PER_BEAT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .lit_wr    (lit_wr),
    .rd_free   (rd_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .beat      (beat)
  );

  assign m_tdata = {3'b000, beat.last, beat.packet_end,
                    beat.pixel[3], beat.pixel[2], beat.pixel[1], beat.pixel[0],
                    beat.pix_count, beat.header};
  assign m_tuser = beat.has_header;
  assign m_tlast = beat.frame_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // classifier never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // every output word carries 1..PIXELS_PER_BEAT pixels
  a_pix_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (beat.pix_count != '0 && beat.pix_count <= PPB))
    else $error("bad pix_count on output word");

  // frame end closes both the packet and the input word's results
  a_frame_close: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && beat.frame_done) |-> (beat.packet_end && beat.last))
    else $error("frame_done without packet_end and last");

  // a repeat packet is a single one-pixel word
  a_repeat_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && beat.has_header && beat.header[7])
      |-> (beat.packet_end && beat.pix_count == 3'd1))
    else $error("malformed repeat packet");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB565 run-length packet encoder.
// A queue of pixel words feeds a falling-edge driver. A rising-edge monitor
// runs the encoder prediction on every accepted pixel and checks each output
// word against the oldest expected word. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 300;    // longest literal packet plus margin
  localparam int RAND_ITEMS  = 40;

  // Pixel word waiting to be sent; hold_off makes the driver wait for drain.
  typedef struct {
    logic [rgbrle_pkg::PIX_W-1:0] px;
    logic                         fe;
    logic                         hold_off;
  } pix_word_t;

  logic clk;
  logic rst = 1'b1;

  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rgbrle_pkg::PIX_W-1:0]     s_tdata  = '0;
  logic                             s_tlast  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rgbrle_pkg::TDATA_W-1:0]   m_tdata;
  logic [0:0]                       m_tuser;
  logic                             m_tlast;

  rgb565_run_length_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Encoder prediction: current run, buffered literals.
  // --------------------------------------------------------------------------
  logic [rgbrle_pkg::PIX_W-1:0] run_px;
  logic                         run_live;
  int                           run_len;
  logic [rgbrle_pkg::PIX_W-1:0] lit_buf [rgbrle_pkg::MAX_PACKET];
  int                           lit_cnt;

  rgbrle_pkg::beat_t step_words [$];   // words caused by the pixel being predicted
  rgbrle_pkg::beat_t words_due  [$];   // expected output words, oldest first

  // Split one packet into words of up to PIXELS_PER_BEAT pixels.
  function automatic void emit_packet(input logic [rgbrle_pkg::HDR_W-1:0] hdr,
                                      input int cnt, input logic rep);
    rgbrle_pkg::beat_t w;
    int                pos;
    int                take;
    pos = 0;
    while (pos < cnt) begin
      take = cnt - pos;
      if (take > rgbrle_pkg::PIXELS_PER_BEAT) take = rgbrle_pkg::PIXELS_PER_BEAT;
      w = '0;
      w.has_header = (pos == 0);
      w.header     = (pos == 0) ? hdr : '0;
      w.pix_count  = rgbrle_pkg::PCNT_W'(take);
      for (int j = 0; j < take; j++) w.pixel[j] = rep ? run_px : lit_buf[pos + j];
      pos += take;
      w.packet_end = (pos >= cnt);
      step_words.push_back(w);
    end
  endfunction

  function automatic void emit_repeat();
    logic [rgbrle_pkg::HDR_W-2:0] len_m1;
    len_m1 = (rgbrle_pkg::HDR_W-1)'(run_len - 1);
    emit_packet({rgbrle_pkg::HDR_REPEAT, len_m1}, 1, 1'b1);
  endfunction

  function automatic void flush_literals();
    logic [rgbrle_pkg::HDR_W-2:0] len_m1;
    if (lit_cnt > 0) begin
      len_m1 = (rgbrle_pkg::HDR_W-1)'(lit_cnt - 1);
      emit_packet({rgbrle_pkg::HDR_LITERAL, len_m1}, lit_cnt, 1'b0);
      lit_cnt = 0;
    end
  endfunction

  // A full literal buffer goes out at once.
  function automatic void add_literal(input logic [rgbrle_pkg::PIX_W-1:0] v);
    if (lit_cnt < rgbrle_pkg::MAX_PACKET) lit_buf[lit_cnt] = v;
    lit_cnt++;
    if (lit_cnt >= rgbrle_pkg::MAX_PACKET) flush_literals();
  endfunction

  function automatic void encode_pixel(input logic [rgbrle_pkg::PIX_W-1:0] px,
                                       input logic fe);
    step_words.delete();
    if (!run_live) begin
      run_px = px; run_live = 1'b1; run_len = 1;
    end else if (px == run_px) begin
      // repeat starts: pending literals go first
      if (run_len == 1) flush_literals();
      run_len++;
      // run at the limit goes out now; next equal pixel opens a new run
      if (run_len >= rgbrle_pkg::MAX_PACKET) begin
        emit_repeat();
        run_live = 1'b0;
        run_len  = 0;
      end
    end else begin
      if (run_len >= 2) emit_repeat();
      else add_literal(run_px);
      run_px = px; run_live = 1'b1; run_len = 1;
    end
    if (fe) begin
      if (run_live) begin
        if (run_len >= 2) emit_repeat();
        else add_literal(run_px);
      end
      flush_literals();
      run_live = 1'b0;
      run_len  = 0;
      if (step_words.size() > 0) step_words[step_words.size() - 1].frame_done = 1'b1;
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) words_due.push_back(step_words[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus queue and its builders.
  // --------------------------------------------------------------------------
  pix_word_t                    pixels_pending [$];
  logic [rgbrle_pkg::PIX_W-1:0] prev_px = '0;
  int                           rand_count = 0;

  function automatic void add_pixel(input logic [rgbrle_pkg::PIX_W-1:0] px,
                                    input logic fe, input logic hold_off = 1'b0);
    pix_word_t w;
    w.px = px; w.fe = fe; w.hold_off = hold_off;
    pixels_pending.push_back(w);
    prev_px = px;
  endfunction

  // Extremes show up more often than a flat draw would give them.
  function automatic logic [rgbrle_pkg::PIX_W-1:0] rand_px();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rgbrle_pkg::PIX_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic void add_run(input int len, input logic fe_at_end);
    logic [rgbrle_pkg::PIX_W-1:0] v;
    v = rand_px();
    for (int i = 0; i < len; i++) add_pixel(v, fe_at_end && (i == len - 1));
  endfunction

  // Every pixel differs from the one before it.
  function automatic void add_literals(input int len, input logic fe_at_end);
    logic [rgbrle_pkg::PIX_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      do v = rand_px(); while (v == prev_px);
      add_pixel(v, fe_at_end && (i == len - 1));
    end
  endfunction

  // Two-color noise: short runs and lone pixels mixed, stray frame ends.
  function automatic void add_noise(input int len);
    logic [rgbrle_pkg::PIX_W-1:0] a;
    logic [rgbrle_pkg::PIX_W-1:0] b;
    a = rand_px();
    b = rand_px();
    for (int i = 0; i < len; i++)
      add_pixel($urandom_range(0, 1) ? a : b, $urandom_range(0, 15) == 0);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one pixel word on the bus at a time, random gaps between words.
  // --------------------------------------------------------------------------
  logic word_on_bus = 1'b0;
  logic px_taken    = 1'b0;   // set by the monitor at the accepting edge
  int   src_gap     = 0;
  logic src_calm    = 1'b0;   // stretch with no gaps

  always @(negedge clk) begin
    pix_word_t nxt;
    if (!rst) begin
      if (px_taken) begin
        px_taken    = 1'b0;
        word_on_bus = 1'b0;
        if ($urandom_range(0, 23) == 0) src_calm = ~src_calm;
        src_gap = src_calm ? 0 : $urandom_range(0, 8);
      end
      if (!word_on_bus && pixels_pending.size() > 0) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (!(pixels_pending[0].hold_off && words_due.size() != 0)) begin
          nxt = pixels_pending.pop_front();
          s_tdata     <= nxt.px;
          s_tlast     <= nxt.fe;
          word_on_bus  = 1'b1;
        end
      end
      s_tvalid <= word_on_bus;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver backpressure: random stall before each output word.
  // --------------------------------------------------------------------------
  logic word_taken = 1'b0;
  int   sink_stall = 0;
  logic sink_calm  = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (word_taken) begin
        word_taken = 1'b0;
        if ($urandom_range(0, 23) == 0) sink_calm = ~sink_calm;
        sink_stall = sink_calm ? 0 : $urandom_range(0, 8);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted pixels, check accepted output words.
  // --------------------------------------------------------------------------
  int mismatches = 0;
  int cycles     = 0;

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rgbrle_pkg::beat_t exp_w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb565_run_length_encoder regression: fail");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      encode_pixel(s_tdata, s_tlast);
      px_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      word_taken = 1'b1;
      if (words_due.size() == 0) begin
        $error("output word with none expected: tdata 0x%0h", m_tdata);
        mismatches++;
      end else begin
        exp_w = words_due.pop_front();
        check_field("has_header", exp_w.has_header, m_tuser[0]);
        check_field("header",     exp_w.header,     m_tdata[7:0]);
        check_field("pix_count",  exp_w.pix_count,  m_tdata[10:8]);
        check_field("pixel_0",    exp_w.pixel[0],   m_tdata[26:11]);
        check_field("pixel_1",    exp_w.pixel[1],   m_tdata[42:27]);
        check_field("pixel_2",    exp_w.pixel[2],   m_tdata[58:43]);
        check_field("pixel_3",    exp_w.pixel[3],   m_tdata[74:59]);
        check_field("packet_end", exp_w.packet_end, m_tdata[75]);
        check_field("frame_done", exp_w.frame_done, m_tlast);
        check_field("last",       exp_w.last,       m_tdata[76]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int   kind;
    int   len;
    int   first_lim;
    logic drained;
    run_px   = '0;
    run_live = 1'b0;
    run_len  = 0;
    lit_cnt  = 0;
    drained  = 1'b0;

    // Directed: lone pixel frame, repeat pair at frame end
    add_pixel(16'h0000, 1'b1);
    add_pixel(16'hFFFF, 1'b0);
    add_pixel(16'hFFFF, 1'b1);
    // literal flushed when a repeat starts, then trailing literal
    add_pixel(16'h1234, 1'b0);
    add_pixel(16'h5678, 1'b0);
    add_pixel(16'h5678, 1'b0);
    add_pixel(16'h9ABC, 1'b1);
    // five literals: one full word plus a single-pixel word
    add_pixel(16'h0001, 1'b0);
    add_pixel(16'h0002, 1'b0);
    add_pixel(16'h0004, 1'b0);
    add_pixel(16'h8000, 1'b0);
    add_pixel(16'h7FFF, 1'b1);
    // back-to-back repeats of different colors
    add_pixel(16'hAAAA, 1'b0);
    add_pixel(16'hAAAA, 1'b0);
    add_pixel(16'hAAAA, 1'b0);
    add_pixel(16'h5555, 1'b0);
    add_pixel(16'h5555, 1'b1);

    // Limits: a literal stretch one past MAX_PACKET fills the buffer, then a
    // run one past MAX_PACKET hits the run limit and opens a new run. The
    // first of these waits for drain.
    first_lim = pixels_pending.size();
    add_literals(rgbrle_pkg::MAX_PACKET + 1, 1'b0);
    pixels_pending[first_lim].hold_off = 1'b1;
    add_run(rgbrle_pkg::MAX_PACKET + 1, 1'b0);

    // Random mix of runs, literal stretches and noise.
    while (rand_count < RAND_ITEMS) begin
      kind = $urandom_range(0, 2);
      case (kind)
        0:       len = $urandom_range(2, 9);
        1:       len = $urandom_range(1, 10);
        default: len = $urandom_range(1, 12);
      endcase
      // drain once in the middle of the random part
      if (!drained && rand_count >= RAND_ITEMS / 2) begin
        pixels_pending[pixels_pending.size() - 1].hold_off = 1'b1;
        drained = 1'b1;
      end
      case (kind)
        0:       add_run(len, $urandom_range(0, 2) == 0);
        1:       add_literals(len, $urandom_range(0, 2) == 0);
        default: add_noise(len);
      endcase
      rand_count += len;
    end
    // close the last frame
    pixels_pending[pixels_pending.size() - 1].fe = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixels_pending.size() != 0 || word_on_bus) @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && words_due.size() == 0) begin
      $display("rgb565_run_length_encoder regression: pass");
    end else begin
      $display("rgb565_run_length_encoder regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rgbrle_pkg.sv
hw/rtl/rgbrle_fifo.sv
hw/rtl/rgbrle_front.sv
hw/rtl/rgbrle_back.sv
hw/rtl/rgb565_run_length_encoder.sv
tb/testbench.sv
